// ----- design/xibd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xibd_pkg: shared types and constants of the instruction byte decoder
// Holds the byte classification record that passes from the front end to
// the decode back end, the decoded result record, and the opcode and prefix
// codes that both sides use.
// ----------------------------------------------------------------------------
package xibd_pkg;

	// Default queue depths.
	localparam int unsigned QUEUE_DEPTH  = 4;
	localparam int unsigned RESULT_DEPTH = 4;

	// Prefix and opcode codes.
	localparam logic [3:0] REX_HIGH_NIBBLE = 4'h4;
	localparam logic [7:0] PREFIX_OPSIZE   = 8'h66;
	localparam logic [7:0] PREFIX_LOCK     = 8'hF0;
	localparam logic [7:0] OPCODE_ESCAPE   = 8'h0F;
	localparam logic [7:0] OPCODE_LEA      = 8'h8D;
	localparam logic [7:0] OPCODE_ADD_IMM  = 8'h05;
	localparam logic [7:0] OPCODE_CALL_REL = 8'hE8;
	localparam logic [7:0] OPCODE_JMP_REL8 = 8'hEB;

	// Status codes on the result.
	localparam logic STATUS_DECODED     = 1'b0;
	localparam logic STATUS_UNSUPPORTED = 1'b1;

	// How many immediate bytes an opcode takes.
	typedef enum logic [1:0] {
		IMM_NONE,
		IMM_ONE,
		IMM_WORD,
		IMM_FOUR
	} imm_kind_t;

	// Every property of one byte that the decode back end may need,
	// whatever phase the byte turns out to belong to.
	typedef struct packed {
		logic [7:0] code;
		logic       is_rex;
		logic       is_opsize;
		logic       is_lock;
		logic       is_escape;
		logic       op_modrm;
		imm_kind_t  imm_kind;
		logic       mr_sib;
		logic       mr_rip;
		logic [2:0] disp_len;
	} byte_class_t;

	// One decoded instruction.
	typedef struct packed {
		logic        status;
		logic        opsize_flag;
		logic        lock_flag;
		logic [7:0]  rex_byte;
		logic        rip_relative;
		logic [7:0]  opcode_byte;
		logic [7:0]  modrm_byte;
		logic [7:0]  sib_byte;
		logic [31:0] displacement;
		logic [31:0] immediate;
	} result_t;

endpackage

// ----- design/xibd_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xibd_fifo: small register queue
// A first-in first-out queue with push/full on the write side and pop/empty
// on the read side. The oldest entry is shown at the read port.
// ----------------------------------------------------------------------------
module xibd_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Pointer and fill count update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// Entry storage needs no reset.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ----- design/xibd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xibd_front: instruction byte classifier
// Looks up every property of an incoming byte at once: prefix kind, opcode
// properties and ModRM properties, so the back end only selects among them.
// ----------------------------------------------------------------------------
module xibd_front (
	input  logic [7:0]            code_byte,
	output xibd_pkg::byte_class_t byte_class
);

	logic [3:0] hi;
	logic [3:0] lo;

	assign hi = code_byte[7:4];
	assign lo = code_byte[3:0];

	// Decode tables for the byte in every role it may play.
	always_comb begin
		byte_class           = '0;
		byte_class.code      = code_byte;
		byte_class.is_rex    = (hi == xibd_pkg::REX_HIGH_NIBBLE);
		byte_class.is_opsize = (code_byte == xibd_pkg::PREFIX_OPSIZE);
		byte_class.is_lock   = (code_byte == xibd_pkg::PREFIX_LOCK);
		byte_class.is_escape = (code_byte == xibd_pkg::OPCODE_ESCAPE);
		byte_class.op_modrm  = (code_byte == xibd_pkg::OPCODE_LEA);

		case (code_byte)
			xibd_pkg::OPCODE_ADD_IMM:  byte_class.imm_kind = xibd_pkg::IMM_WORD;
			xibd_pkg::OPCODE_CALL_REL: byte_class.imm_kind = xibd_pkg::IMM_FOUR;
			xibd_pkg::OPCODE_JMP_REL8: byte_class.imm_kind = xibd_pkg::IMM_ONE;
			default:                   byte_class.imm_kind = xibd_pkg::IMM_NONE;
		endcase

		// SIB follows ModRM rows 2, 6 and A with a low nibble below 8.
		byte_class.mr_sib = ((hi == 4'h2) || (hi == 4'h6) || (hi == 4'hA)) && !lo[3];
		// Mod 0 with rm 5 selects RIP-relative addressing.
		byte_class.mr_rip = (code_byte[7:6] == 2'b00) && (code_byte[2:0] == 3'd5);

		// Displacement length.
		if (hi == 4'h4) begin
			byte_class.disp_len = 3'd1;
		end else if (hi == 4'h8) begin
			byte_class.disp_len = 3'd4;
		end else if ((hi <= 4'h3) && ((lo == 4'h5) || (lo == 4'hD))) begin
			byte_class.disp_len = 3'd4;
		end else if ((hi == 4'h2) && lo[3]) begin
			byte_class.disp_len = 3'd4;
		end else begin
			byte_class.disp_len = 3'd0;
		end
	end

endmodule

// ----- design/xibd_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xibd_back: decode sequencer
// Walks the prefix, opcode, ModRM, SIB, displacement and immediate phases one
// classified byte per cycle when not stalled and pushes finished instructions.
// ----------------------------------------------------------------------------
module xibd_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_empty,
	input  xibd_pkg::byte_class_t in_class,
	output logic                  in_pop,
	input  logic                  out_full,
	output logic                  out_push,
	output xibd_pkg::result_t     out_result
);

	typedef enum logic [2:0] {
		PH_PREFIX,
		PH_MODRM,
		PH_SIB,
		PH_DISP,
		PH_IMM
	} phase_t;

	phase_t      phase_q,    n_phase;
	logic        opsize_q,   n_opsize;
	logic        lock_q,     n_lock;
	logic [7:0]  rex_q,      n_rex;
	logic        rip_q,      n_rip;
	logic [7:0]  opcode_q,   n_opcode;
	logic        op_modrm_q, n_op_modrm;
	logic [7:0]  modrm_q,    n_modrm;
	logic [7:0]  sib_q,      n_sib;
	logic [31:0] disp_q,     n_disp;
	logic [31:0] imm_q,      n_imm;
	logic [2:0]  disp_cnt_q, n_disp_cnt;
	logic [2:0]  imm_cnt_q,  n_imm_cnt;
	logic [2:0]  disp_len_q, n_disp_len;
	logic [2:0]  imm_len_q,  n_imm_len;
	logic        take;
	logic        done;
	logic        done_status;

	// A byte is taken whenever one waits and the result queue has room.
	assign take   = !in_empty && !out_full;
	assign in_pop = take;

	// Next field values for the byte in hand, then the pass through phases
	// that consume no byte.
	always_comb begin
		n_phase     = phase_q;
		n_opsize    = opsize_q;
		n_lock      = lock_q;
		n_rex       = rex_q;
		n_rip       = rip_q;
		n_opcode    = opcode_q;
		n_op_modrm  = op_modrm_q;
		n_modrm     = modrm_q;
		n_sib       = sib_q;
		n_disp      = disp_q;
		n_imm       = imm_q;
		n_disp_cnt  = disp_cnt_q;
		n_imm_cnt   = imm_cnt_q;
		n_disp_len  = disp_len_q;
		n_imm_len   = imm_len_q;
		done        = 1'b0;
		done_status = xibd_pkg::STATUS_DECODED;

		if (take) begin
			case (phase_q)
				PH_MODRM: begin
					n_modrm    = in_class.code;
					n_disp_len = in_class.disp_len;
					if (in_class.mr_rip) begin
						n_rip   = 1'b1;
						n_phase = PH_DISP;
					end else if (in_class.mr_sib) begin
						n_phase = PH_SIB;
					end else begin
						n_phase = PH_DISP;
					end
				end
				PH_SIB: begin
					n_sib   = in_class.code;
					n_phase = PH_DISP;
				end
				PH_DISP: begin
					n_disp     = disp_q | ({24'd0, in_class.code} << {disp_cnt_q[1:0], 3'd0});
					n_disp_cnt = disp_cnt_q + 3'd1;
				end
				PH_IMM: begin
					n_imm     = imm_q | ({24'd0, in_class.code} << {imm_cnt_q[1:0], 3'd0});
					n_imm_cnt = imm_cnt_q + 3'd1;
				end
				default: begin
					n_phase = PH_PREFIX;
					if (in_class.is_rex) begin
						n_rex = in_class.code;
					end else if (in_class.is_opsize) begin
						n_opsize = 1'b1;
					end else if (in_class.is_lock) begin
						n_lock = 1'b1;
					end else begin
						n_opcode   = in_class.code;
						n_op_modrm = in_class.op_modrm;
						case (in_class.imm_kind)
							xibd_pkg::IMM_ONE:  n_imm_len = 3'd1;
							xibd_pkg::IMM_WORD: n_imm_len = rex_q[3] ? 3'd4 : 3'd2;
							xibd_pkg::IMM_FOUR: n_imm_len = 3'd4;
							default:            n_imm_len = 3'd0;
						endcase
						if (in_class.is_escape) begin
							done        = 1'b1;
							done_status = xibd_pkg::STATUS_UNSUPPORTED;
						end else begin
							n_phase = PH_MODRM;
						end
					end
				end
			endcase

			// Skip phases that have nothing left to consume.
			if (!done) begin
				if ((n_phase == PH_MODRM) && !n_op_modrm) begin
					n_phase = PH_IMM;
				end
				if ((n_phase == PH_DISP) && (n_disp_cnt >= n_disp_len)) begin
					n_phase = PH_IMM;
				end
				if ((n_phase == PH_IMM) && (n_imm_cnt >= n_imm_len)) begin
					done = 1'b1;
				end
			end
		end
	end

	// The finished instruction carries the fields as they stand after this byte.
	assign out_push = done;
	always_comb begin
		out_result.status       = done_status;
		out_result.opsize_flag  = n_opsize;
		out_result.lock_flag    = n_lock;
		out_result.rex_byte     = n_rex;
		out_result.rip_relative = n_rip;
		out_result.opcode_byte  = n_opcode;
		out_result.modrm_byte   = n_modrm;
		out_result.sib_byte     = n_sib;
		out_result.displacement = n_disp;
		out_result.immediate    = n_imm;
	end

	// Held decode state; cleared after every finished instruction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_PREFIX;
			opsize_q   <= 1'b0;
			lock_q     <= 1'b0;
			rex_q      <= '0;
			rip_q      <= 1'b0;
			opcode_q   <= '0;
			op_modrm_q <= 1'b0;
			modrm_q    <= '0;
			sib_q      <= '0;
			disp_q     <= '0;
			imm_q      <= '0;
			disp_cnt_q <= '0;
			imm_cnt_q  <= '0;
			disp_len_q <= '0;
			imm_len_q  <= '0;
		end else if (done) begin
			phase_q    <= PH_PREFIX;
			opsize_q   <= 1'b0;
			lock_q     <= 1'b0;
			rex_q      <= '0;
			rip_q      <= 1'b0;
			opcode_q   <= '0;
			op_modrm_q <= 1'b0;
			modrm_q    <= '0;
			sib_q      <= '0;
			disp_q     <= '0;
			imm_q      <= '0;
			disp_cnt_q <= '0;
			imm_cnt_q  <= '0;
			disp_len_q <= '0;
			imm_len_q  <= '0;
		end else begin
			phase_q    <= n_phase;
			opsize_q   <= n_opsize;
			lock_q     <= n_lock;
			rex_q      <= n_rex;
			rip_q      <= n_rip;
			opcode_q   <= n_opcode;
			op_modrm_q <= n_op_modrm;
			modrm_q    <= n_modrm;
			sib_q      <= n_sib;
			disp_q     <= n_disp;
			imm_q      <= n_imm;
			disp_cnt_q <= n_disp_cnt;
			imm_cnt_q  <= n_imm_cnt;
			disp_len_q <= n_disp_len;
			imm_len_q  <= n_imm_len;
		end
	end

endmodule

// ----- design/x86_instruction_byte_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86_instruction_byte_decoder: one-byte-per-cycle instruction decoder
// Splits a byte stream into instructions made of prefixes, a one-byte
// opcode, ModRM, SIB, displacement and immediate fields.
// ----------------------------------------------------------------------------
// Usage:
// The input side looks like a queue: drive code_byte with push high; a byte
// transfers at a clock edge where push is high and full is low.
// The result side also looks like a queue: while empty is low the oldest
// decoded instruction is on the result ports, and it transfers at a clock
// edge where pop is high. An instruction ending in the unsupported 0x0F
// escape comes out with status set and the decoder starts over.
// The byte that finishes an instruction waits in the byte queue, and the
// decode sequencer writes the result into the result queue at the edge
// that takes the byte; from there the result shows on the result ports.
// Throughput is one byte per cycle while the result queue has room, set by
// the decode step that updates the held fields as each byte is taken.
// When pop stays low the result queue fills, the sequencer stops taking
// bytes, and full rises once the byte queue is full as well; no byte and
// no result is lost. Reset clears both queues and all held decode state.
// ----------------------------------------------------------------------------
module x86_instruction_byte_decoder #(
	parameter int unsigned QUEUE_DEPTH  = xibd_pkg::QUEUE_DEPTH,
	parameter int unsigned RESULT_DEPTH = xibd_pkg::RESULT_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  code_byte,
	output logic        empty,
	input  logic        pop,
	output logic        status,
	output logic        opsize_flag,
	output logic        lock_flag,
	output logic [7:0]  rex_byte,
	output logic        rip_relative,
	output logic [7:0]  opcode_byte,
	output logic [7:0]  modrm_byte,
	output logic [7:0]  sib_byte,
	output logic [31:0] displacement,
	output logic [31:0] immediate
);

	localparam int unsigned CLASS_W  = $bits(xibd_pkg::byte_class_t);
	localparam int unsigned RESULT_W = $bits(xibd_pkg::result_t);

	xibd_pkg::byte_class_t front_class;
	xibd_pkg::byte_class_t queued_class;
	xibd_pkg::result_t     back_result;
	xibd_pkg::result_t     head_result;
	logic                  q_empty;
	logic                  q_pop;
	logic                  r_full;
	logic                  r_push;

	// Front end: classify the byte on its way into the byte queue.
	xibd_front u_front (
		.code_byte  (code_byte),
		.byte_class (front_class)
	);

	xibd_fifo #(
		.WIDTH (CLASS_W),
		.DEPTH (QUEUE_DEPTH)
	) u_byte_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (front_class),
		.full    (full),
		.pop     (q_pop),
		.rd_data (queued_class),
		.empty   (q_empty)
	);

	// Back end: decode sequencer.
	xibd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_empty   (q_empty),
		.in_class   (queued_class),
		.in_pop     (q_pop),
		.out_full   (r_full),
		.out_push   (r_push),
		.out_result (back_result)
	);

	xibd_fifo #(
		.WIDTH (RESULT_W),
		.DEPTH (RESULT_DEPTH)
	) u_result_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (r_push),
		.wr_data (back_result),
		.full    (r_full),
		.pop     (pop),
		.rd_data (head_result),
		.empty   (empty)
	);

	// Result ports.
	assign status       = head_result.status;
	assign opsize_flag  = head_result.opsize_flag;
	assign lock_flag    = head_result.lock_flag;
	assign rex_byte     = head_result.rex_byte;
	assign rip_relative = head_result.rip_relative;
	assign opcode_byte  = head_result.opcode_byte;
	assign modrm_byte   = head_result.modrm_byte;
	assign sib_byte     = head_result.sib_byte;
	assign displacement = head_result.displacement;
	assign immediate    = head_result.immediate;

endmodule

// ----- design/xibd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xibd_checker: port-level checks of the instruction byte decoder
// Watches the result side and checks that each shown instruction is
// consistent with the decode rules, and that a stalled result stays put.
// ----------------------------------------------------------------------------
module xibd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic        status,
	input logic [7:0]  rex_byte,
	input logic        rip_relative,
	input logic [7:0]  opcode_byte,
	input logic [7:0]  modrm_byte,
	input logic [7:0]  sib_byte,
	input logic [31:0] displacement
);

	// An unsupported result always carries the escape opcode, and nothing else does.
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ((status == xibd_pkg::STATUS_UNSUPPORTED) ==
			(opcode_byte == xibd_pkg::OPCODE_ESCAPE)))
		else $error("status does not match the escape opcode");

	// RIP-relative mode comes only from ModRM mod 0, rm 5.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && rip_relative) |-> ((modrm_byte[7:6] == 2'b00) && (modrm_byte[2:0] == 3'd5)))
		else $error("rip_relative without a matching ModRM byte");

	// Opcodes without ModRM carry no ModRM, SIB or displacement.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (opcode_byte != xibd_pkg::OPCODE_LEA)) |->
			((modrm_byte == 8'd0) && (sib_byte == 8'd0) && (displacement == 32'd0)))
		else $error("addressing fields present without a ModRM opcode");

	// A held REX byte is always a REX prefix.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (rex_byte != 8'd0)) |-> (rex_byte[7:4] == xibd_pkg::REX_HIGH_NIBBLE))
		else $error("rex_byte is not a REX prefix");

	// A result that is not popped stays on the ports.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(opcode_byte) && $stable(displacement)))
		else $error("stalled result changed");

endmodule

bind x86_instruction_byte_decoder xibd_checker u_xibd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.empty        (empty),
	.pop          (pop),
	.status       (status),
	.rex_byte     (rex_byte),
	.rip_relative (rip_relative),
	.opcode_byte  (opcode_byte),
	.modrm_byte   (modrm_byte),
	.sib_byte     (sib_byte),
	.displacement (displacement)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the x86 instruction byte decoder
// Feeds a byte stream through the input queue, predicts each decoded
// instruction in a scoreboard that walks the same decode phases, and
// compares every popped result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned STALL_CYCLES = 400;

	// Directed stream: a bare opcode, stacked prefixes ending in the escape,
	// 0x67 taken as an opcode, a REX.W widened immediate, a short jump, a
	// RIP-relative LEA and a LEA with a SIB byte and no displacement.
	localparam logic [7:0] DIRECTED_BYTES [24] = '{
		8'h90,
		8'h66, 8'hF0, 8'h41, 8'h4F, 8'h0F,
		8'h67,
		8'h48, 8'h05, 8'hFF, 8'h00, 8'h00, 8'hFF,
		8'hEB, 8'h80,
		8'h8D, 8'h05, 8'hDD, 8'hCC, 8'hBB, 8'hAA,
		8'h8D, 8'h24, 8'h00
	};

	typedef enum logic [2:0] {
		PH_PREFIX,
		PH_MODRM,
		PH_SIB,
		PH_DISP,
		PH_IMM
	} decode_phase_t;

	// Scoreboard: keeps its own copy of the decode state and a queue of
	// instructions that the block owes.
	class instruction_scoreboard;
		decode_phase_t phase;
		logic        opsize;
		logic        lock;
		logic [7:0]  rex;
		logic        rip;
		logic [7:0]  opcode;
		logic [7:0]  modrm;
		logic [7:0]  sib;
		logic [31:0] disp;
		logic [31:0] imm;
		logic [2:0]  disp_cnt;
		logic [2:0]  imm_cnt;
		xibd_pkg::result_t decoded_q[$];
		int          errors;

		function new();
			errors = 0;
			clear_held();
		endfunction

		function void clear_held();
			phase = PH_PREFIX;
			opsize = 1'b0;
			lock = 1'b0;
			rex = 8'h00;
			rip = 1'b0;
			opcode = 8'h00;
			modrm = 8'h00;
			sib = 8'h00;
			disp = 32'h0;
			imm = 32'h0;
			disp_cnt = 3'd0;
			imm_cnt = 3'd0;
		endfunction

		function bit in_instruction();
			return phase != PH_PREFIX;
		endfunction

		function int pending();
			return decoded_q.size();
		endfunction

		function bit needs_sib(logic [7:0] m);
			return (m[7:4] == 4'h2 || m[7:4] == 4'h6 || m[7:4] == 4'hA) && m[3:0] < 4'd8;
		endfunction

		function int unsigned disp_bytes(logic [7:0] m);
			if (m[7:4] == 4'h4)
				return 1;
			if (m[7:4] == 4'h8)
				return 4;
			if (m[7:4] <= 4'h3 && (m[3:0] == 4'h5 || m[3:0] == 4'hD))
				return 4;
			if (m[7:4] == 4'h2 && m[3:0] >= 4'h8)
				return 4;
			return 0;
		endfunction

		function int unsigned imm_bytes(logic [7:0] op, logic [7:0] r);
			if (op == xibd_pkg::OPCODE_ADD_IMM)
				return r[3] ? 4 : 2;
			if (op == xibd_pkg::OPCODE_CALL_REL)
				return 4;
			if (op == xibd_pkg::OPCODE_JMP_REL8)
				return 1;
			return 0;
		endfunction

		// Queue the finished instruction and start over.
		function void finish_instruction(logic st);
			xibd_pkg::result_t r;
			r.status = st;
			r.opsize_flag = opsize;
			r.lock_flag = lock;
			r.rex_byte = rex;
			r.rip_relative = rip;
			r.opcode_byte = opcode;
			r.modrm_byte = modrm;
			r.sib_byte = sib;
			r.displacement = disp;
			r.immediate = imm;
			decoded_q.push_back(r);
			clear_held();
		endfunction

		// Skip the phases that take no byte and finish when nothing is left.
		function void advance_phase();
			if (phase == PH_MODRM && opcode != xibd_pkg::OPCODE_LEA)
				phase = PH_IMM;
			if (phase == PH_DISP && disp_cnt >= disp_bytes(modrm))
				phase = PH_IMM;
			if (phase == PH_IMM && imm_cnt >= imm_bytes(opcode, rex))
				finish_instruction(xibd_pkg::STATUS_DECODED);
		endfunction

		// Note one byte that transferred into the block.
		function void decode_byte(logic [7:0] b);
			case (phase)
				PH_MODRM: begin
					modrm = b;
					if (b[7:6] == 2'd0 && b[2:0] == 3'd5) begin
						rip = 1'b1;
						phase = PH_DISP;
					end else begin
						phase = needs_sib(b) ? PH_SIB : PH_DISP;
					end
					advance_phase();
				end
				PH_SIB: begin
					sib = b;
					phase = PH_DISP;
					advance_phase();
				end
				PH_DISP: begin
					disp = disp | (32'(b) << (8 * disp_cnt[1:0]));
					disp_cnt = disp_cnt + 3'd1;
					advance_phase();
				end
				PH_IMM: begin
					imm = imm | (32'(b) << (8 * imm_cnt[1:0]));
					imm_cnt = imm_cnt + 3'd1;
					advance_phase();
				end
				default: begin
					phase = PH_PREFIX;
					if (b[7:4] == xibd_pkg::REX_HIGH_NIBBLE) begin
						rex = b;
					end else if (b == xibd_pkg::PREFIX_OPSIZE) begin
						opsize = 1'b1;
					end else if (b == xibd_pkg::PREFIX_LOCK) begin
						lock = 1'b1;
					end else begin
						opcode = b;
						if (b == xibd_pkg::OPCODE_ESCAPE) begin
							finish_instruction(xibd_pkg::STATUS_UNSUPPORTED);
						end else begin
							phase = PH_MODRM;
							advance_phase();
						end
					end
				end
			endcase
		endfunction

		function void check_field(string field, logic [31:0] want, logic [31:0] seen);
			if (want !== seen) begin
				$display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
					$time, field, want, seen);
				errors++;
			end
		endfunction

		// Compare one popped result with the oldest prediction.
		function void check_result(xibd_pkg::result_t got);
			xibd_pkg::result_t want;
			if (decoded_q.size() == 0) begin
				$display("%0t ns: result with none expected, actual 0x%0h", $time, got);
				errors++;
				return;
			end
			want = decoded_q.pop_front();
			check_field("status", 32'(want.status), 32'(got.status));
			check_field("opsize_flag", 32'(want.opsize_flag), 32'(got.opsize_flag));
			check_field("lock_flag", 32'(want.lock_flag), 32'(got.lock_flag));
			check_field("rex_byte", 32'(want.rex_byte), 32'(got.rex_byte));
			check_field("rip_relative", 32'(want.rip_relative), 32'(got.rip_relative));
			check_field("opcode_byte", 32'(want.opcode_byte), 32'(got.opcode_byte));
			check_field("modrm_byte", 32'(want.modrm_byte), 32'(got.modrm_byte));
			check_field("sib_byte", 32'(want.sib_byte), 32'(got.sib_byte));
			check_field("displacement", want.displacement, got.displacement);
			check_field("immediate", want.immediate, got.immediate);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic [7:0]  code_byte = 8'h00;
	logic        pop = 1'b0;
	logic        full;
	logic        empty;
	logic        status;
	logic        opsize_flag;
	logic        lock_flag;
	logic [7:0]  rex_byte;
	logic        rip_relative;
	logic [7:0]  opcode_byte;
	logic [7:0]  modrm_byte;
	logic [7:0]  sib_byte;
	logic [31:0] displacement;
	logic [31:0] immediate;

	int unsigned send_idle = 9;
	int unsigned recv_idle = 60;
	int unsigned bytes_sent = 0;
	bit          hold_req = 1'b0;
	instruction_scoreboard sb = new();

	x86_instruction_byte_decoder i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.code_byte    (code_byte),
		.empty        (empty),
		.pop          (pop),
		.status       (status),
		.opsize_flag  (opsize_flag),
		.lock_flag    (lock_flag),
		.rex_byte     (rex_byte),
		.rip_relative (rip_relative),
		.opcode_byte  (opcode_byte),
		.modrm_byte   (modrm_byte),
		.sib_byte     (sib_byte),
		.displacement (displacement),
		.immediate    (immediate)
	);

	// Clock with a 20 ns period.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Offer one byte, idling at random first, and return once it transfers.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			code_byte <= 8'($urandom);
			@(posedge clk);
		end
		push <= 1'b1;
		code_byte <= b;
		do
			@(posedge clk);
		while (full);
		sb.decode_byte(b);
		bytes_sent++;
	endtask

	// Send a well-formed instruction with random prefixes and content.
	task automatic send_instruction();
		int unsigned n_prefix;
		int unsigned pick;
		logic [7:0]  op;
		n_prefix = ($urandom_range(99) < 60) ? 0 : $urandom_range(1, 3);
		repeat (n_prefix) begin
			case ($urandom_range(2))
				0: send_byte({xibd_pkg::REX_HIGH_NIBBLE, 4'($urandom)});
				1: send_byte(xibd_pkg::PREFIX_OPSIZE);
				default: send_byte(xibd_pkg::PREFIX_LOCK);
			endcase
		end
		pick = $urandom_range(99);
		if (pick < 35)
			op = xibd_pkg::OPCODE_LEA;
		else if (pick < 50)
			op = xibd_pkg::OPCODE_ADD_IMM;
		else if (pick < 60)
			op = xibd_pkg::OPCODE_CALL_REL;
		else if (pick < 70)
			op = xibd_pkg::OPCODE_JMP_REL8;
		else if (pick < 75)
			op = xibd_pkg::OPCODE_ESCAPE;
		else
			op = 8'($urandom);
		send_byte(op);
		// The remaining bytes lean toward all zeros and all ones.
		while (sb.in_instruction()) begin
			pick = $urandom_range(9);
			send_byte(pick == 0 ? 8'h00 : (pick == 1 ? 8'hFF : 8'($urandom)));
		end
	endtask

	// Mostly whole instructions, with loose bytes mixed in.
	task automatic send_random_until(input int unsigned count);
		while (bytes_sent < count) begin
			if ($urandom_range(99) < 85)
				send_instruction();
			else
				send_byte(8'($urandom));
		end
	endtask

	// Result side: check each transfer and pick the next pop, with one long
	// hold-off when requested so that both queues fill.
	initial begin
		int unsigned       hold_left;
		xibd_pkg::result_t got;
		hold_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				got = {status, opsize_flag, lock_flag, rex_byte, rip_relative,
					opcode_byte, modrm_byte, sib_byte, displacement, immediate};
				sb.check_result(got);
			end
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = STALL_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	// Guard against a hang.
	initial begin
		int unsigned cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// Main sequence.
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED_BYTES[i])
			send_byte(DIRECTED_BYTES[i]);
		send_random_until(320);

		send_idle = 60;
		recv_idle = 9;
		send_random_until(640);

		// No idling on either side; the receiver first holds off for a while.
		send_idle = 0;
		recv_idle = 0;
		hold_req = 1'b1;
		send_random_until(975);
		push <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- sim.f -----
design/xibd_pkg.sv
design/xibd_fifo.sv
design/xibd_front.sv
design/xibd_back.sv
design/x86_instruction_byte_decoder.sv
design/xibd_checker.sv
tb/testbench.sv
